// ----- sv/khf_pkg.sv -----
`default_nettype none

package khf_pkg;

    localparam int BUTTONS_DEF = 16;

    localparam int FUNC_W = 3;
    localparam int BUTTON_W = 4;
    localparam int KEY_W = 10;
    localparam int TIME_W = 31;
    localparam int MS_W = 32;
    localparam int FRAME_W = 10;
    localparam int FRAC_W = 17;
    localparam int QUOT_W = 16;
    localparam int SUM_W = 34;

    localparam logic [FRAME_W-1:0] MAX_FRAME_RESET = 10'd200;
    localparam logic [FRAC_W-1:0] FRAC_WHOLE = 17'h10000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_KEY_DOWN    = 3'd0,
        FUNC_KEY_UP      = 3'd1,
        FUNC_RELEASE_ALL = 3'd2,
        FUNC_FRAME_TICK  = 3'd3,
        FUNC_SAMPLE      = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  first_key;
        logic [KEY_W-1:0]  second_key;
        logic              held;
        logic              pressed;
        logic [TIME_W-1:0] press_time;
        logic [MS_W-1:0]   held_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- sv/khf_in_if.sv -----
`default_nettype none

interface khf_in_if
    import khf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [BUTTON_W-1:0] button;
    logic [KEY_W-1:0]    key_code;
    logic [TIME_W-1:0]   event_time;

    modport source (output valid, output func, output button, output key_code,
                    output event_time, input ready);
    modport sink (input valid, input func, input button, input key_code,
                  input event_time, output ready);
endinterface

`default_nettype wire

// ----- sv/khf_out_if.sv -----
`default_nettype none

interface khf_out_if
    import khf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] hold_fraction;
    logic              button_flag;
    logic              held;

    modport source (output valid, output hold_fraction, output button_flag,
                    output held, input ready);
    modport sink (input valid, input hold_fraction, input button_flag,
                  input held, output ready);
endinterface

`default_nettype wire

// ----- sv/khf_ram.sv -----
`default_nettype none

module khf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/key_hold_fraction_meter.sv -----
// channel | dir | beat contents
// in_ch   | in  | func, button, key_code, event_time
// out_ch  | out | hold_fraction, button_flag, held (one beat per sample)
//
// key events: accept with entry read, then modify and write back
// a sample runs exec and prep, then the 16-step restoring divider unless the result is zero or whole
// frame ticks and ignored codes finish in the accept cycle
// per-button state sits in one ram; valid flops make unwritten entries read as zero
// in_ch stalls while an item is in flight or a result cannot enter the output register
`default_nettype none

module key_hold_fraction_meter
    import khf_pkg::*;
#(
    parameter int BUTTONS = BUTTONS_DEF,
    localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [FRAME_W-1:0] cfg_wr_data,
    khf_in_if.sink                  in_ch,
    khf_out_if.source               out_ch
);

    state_t               state_reg, state_next;
    logic [FRAME_W-1:0]   max_frame_reg;
    logic [FRAME_W-1:0]   frame_width_reg, frame_width_next;
    logic [TIME_W-1:0]    last_tick_reg, last_tick_next;
    logic [BUTTONS-1:0]   valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           cnt_reg, cnt_next;

    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [KEY_W-1:0]     code_reg, code_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [SUM_W-1:0]     ms_reg, ms_next;
    logic [FRAME_W-1:0]   rem_reg, rem_next;
    logic [QUOT_W-1:0]    quot_reg, quot_next;
    logic [FRAC_W-1:0]    res_frac_reg, res_frac_next;
    logic                 res_flag_reg, res_flag_next;
    logic                 res_held_reg, res_held_next;
    logic [FRAC_W-1:0]    hold_fraction_reg;
    logic                 button_flag_reg;
    logic                 held_reg;

    logic                 accept;
    logic                 out_load;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_rdata;
    entry_t               ent;
    entry_t               upd;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign ram_we = (state_reg == ST_EXEC);
    assign ent = valid_reg[addr_reg] ? entry_t'(ram_rdata) : entry_t'('0);

    khf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ENTRY_W'(upd)),
        .re    (accept),
        .raddr (AW'(in_ch.button)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic                  btn_ok;
        logic [TIME_W-1:0]     gap;
        logic [FRAME_W:0]      trial;
        logic [TIME_W-1:0]     t;

        state_next       = state_reg;
        frame_width_next = frame_width_reg;
        last_tick_next   = last_tick_reg;
        valid_next       = valid_reg;
        out_valid_next   = out_valid_reg;
        cnt_next         = cnt_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        code_next        = code_reg;
        time_next        = time_reg;
        ms_next          = ms_reg;
        rem_next         = rem_reg;
        quot_next        = quot_reg;
        res_frac_next    = res_frac_reg;
        res_flag_next    = res_flag_reg;
        res_held_next    = res_held_reg;
        out_load         = 1'b0;
        upd              = ent;
        t                = in_ch.event_time;
        btn_ok           = (32'(in_ch.button) < 32'(BUTTONS));
        gap              = t - last_tick_reg;
        trial            = {rem_reg, 1'b0};

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_ch.func;
                    addr_next = AW'(in_ch.button);
                    code_next = in_ch.key_code;
                    time_next = t;
                    case (in_ch.func)
                        FUNC_KEY_DOWN, FUNC_KEY_UP, FUNC_RELEASE_ALL:
                        begin
                            if (btn_ok)
                            begin
                                state_next = ST_EXEC;
                            end
                        end
                        FUNC_FRAME_TICK:
                        begin
                            if (t < last_tick_reg)
                            begin
                                frame_width_next = max_frame_reg;
                            end
                            else if (t == last_tick_reg)
                            begin
                                frame_width_next = (max_frame_reg == '0) ? '0 : FRAME_W'(1);
                            end
                            else if (gap > TIME_W'(max_frame_reg))
                            begin
                                frame_width_next = max_frame_reg;
                            end
                            else
                            begin
                                frame_width_next = gap[FRAME_W-1:0];
                            end
                            last_tick_next = t;
                        end
                        FUNC_SAMPLE:
                        begin
                            if (btn_ok)
                            begin
                                state_next = ST_EXEC;
                            end
                            else
                            begin
                                res_frac_next = '0;
                                res_flag_next = 1'b0;
                                res_held_next = 1'b0;
                                state_next    = ST_OUT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                valid_next[addr_reg] = 1'b1;
                state_next = ST_IDLE;
                case (func_reg)
                    FUNC_KEY_DOWN:
                    begin
                        if (code_reg != ent.first_key && code_reg != ent.second_key
                            && !(ent.first_key != '0 && ent.second_key != '0))
                        begin
                            if (ent.first_key != '0)
                            begin
                                upd.second_key = code_reg;
                            end
                            else
                            begin
                                upd.first_key = code_reg;
                            end
                            if (!ent.held)
                            begin
                                upd.press_time = time_reg;
                                upd.held       = 1'b1;
                                upd.pressed    = 1'b1;
                            end
                        end
                    end
                    FUNC_KEY_UP:
                    begin
                        if (code_reg != '0
                            && (ent.first_key == code_reg || ent.second_key == code_reg))
                        begin
                            if (ent.first_key == code_reg)
                            begin
                                upd.first_key = '0;
                            end
                            else
                            begin
                                upd.second_key = '0;
                            end
                            if (upd.first_key == '0 && upd.second_key == '0)
                            begin
                                upd.held = 1'b0;
                                if (time_reg != '0)
                                begin
                                    upd.held_ms = ent.held_ms + MS_W'(time_reg)
                                                  - MS_W'(ent.press_time);
                                end
                                else
                                begin
                                    upd.held_ms = ent.held_ms
                                                  + MS_W'(frame_width_reg[FRAME_W-1:1]);
                                end
                            end
                        end
                    end
                    FUNC_RELEASE_ALL:
                    begin
                        upd.first_key  = '0;
                        upd.second_key = '0;
                        upd.held       = 1'b0;
                    end
                    FUNC_SAMPLE:
                    begin
                        res_flag_next = ent.held || ent.pressed;
                        res_held_next = ent.held;
                        if (!ent.held)
                        begin
                            ms_next = {{(SUM_W-MS_W){ent.held_ms[MS_W-1]}}, ent.held_ms};
                        end
                        else if (ent.press_time == '0)
                        begin
                            ms_next = SUM_W'(time_reg);
                        end
                        else
                        begin
                            ms_next = {{(SUM_W-MS_W){ent.held_ms[MS_W-1]}}, ent.held_ms}
                                      + SUM_W'(time_reg) - SUM_W'(ent.press_time);
                        end
                        if (ent.held)
                        begin
                            upd.press_time = time_reg;
                        end
                        upd.held_ms = '0;
                        upd.pressed = 1'b0;
                        state_next  = ST_PREP;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_PREP:
            begin
                if (ms_reg[SUM_W-1] || ms_reg == '0)
                begin
                    res_frac_next = '0;
                    state_next    = ST_OUT;
                end
                else if (ms_reg >= SUM_W'(frame_width_reg))
                begin
                    res_frac_next = FRAC_WHOLE;
                    state_next    = ST_OUT;
                end
                else
                begin
                    rem_next   = ms_reg[FRAME_W-1:0];
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, frame_width_reg})
                begin
                    rem_next  = FRAME_W'(trial - {1'b0, frame_width_reg});
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[FRAME_W-1:0];
                    quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    res_frac_next = {1'b0, quot_next};
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_frame_reg   <= MAX_FRAME_RESET;
            frame_width_reg <= '0;
            last_tick_reg   <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_width_reg <= frame_width_next;
            last_tick_reg   <= last_tick_next;
            valid_reg       <= valid_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            if (cfg_wr_en)
            begin
                max_frame_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        addr_reg     <= addr_next;
        code_reg     <= code_next;
        time_reg     <= time_next;
        ms_reg       <= ms_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        res_frac_reg <= res_frac_next;
        res_flag_reg <= res_flag_next;
        res_held_reg <= res_held_next;
        if (out_load)
        begin
            hold_fraction_reg <= res_frac_reg;
            button_flag_reg   <= res_flag_reg;
            held_reg          <= res_held_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.hold_fraction = hold_fraction_reg;
    assign out_ch.button_flag   = button_flag_reg;
    assign out_ch.held          = held_reg;

    // result never exceeds one whole frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> hold_fraction_reg <= FRAC_WHOLE)
        else $error("hold fraction above one frame");

    // held implies the flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!held_reg || button_flag_reg))
        else $error("held without button flag");

    // divider remainder stays below the frame width
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < frame_width_reg)
        else $error("divider remainder out of range");

    // one key code never sits in both slots
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && ent.first_key != '0) |-> ent.first_key != ent.second_key)
        else $error("duplicate key code in slots");

    // a loaded result beat comes only from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result beat from wrong state");

endmodule

`default_nettype wire
